@@ hdl/kss_pkg.sv @@
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants of the k-sorted stream sorter: item structs,
// heap geometry and the controller state codes.
// ----------------------------------------------------------------------------
package kss_pkg;

	// heap geometry
	localparam int HEAP_DEPTH = 32;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int WIN_W      = 5;
	localparam int DATA_W     = 32;

	// one input item
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_final;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     is_last;
	} out_item_t;

	// controller states
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RD_TOP = 7'b0000010,
		S_EMIT   = 7'b0000100,
		S_DN_RD  = 7'b0001000,
		S_DN_CMP = 7'b0010000,
		S_UP_RD  = 7'b0100000,
		S_UP_CMP = 7'b1000000
	} state_t;

endpackage

@@ hdl/kss_ram.sv @@
// ----------------------------------------------------------------------------
// kss_ram
// Generic RAM: one write port and two read ports, read data registered,
// held while no read is enabled.
// ----------------------------------------------------------------------------
module kss_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ hdl/kss_out_buf.sv @@
// ----------------------------------------------------------------------------
// kss_out_buf
// Output register of the sorter: holds one result item until it is taken,
// so the controller can go on while the consumer stalls.
// ----------------------------------------------------------------------------
module kss_out_buf
	import kss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      push_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      valid_q;
	out_item_t item_q;

	// slot is free when empty or being drained this cycle
	assign push_ok = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			item_q <= push_item;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

@@ hdl/k_sorted_stream_sorter.sv @@
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter
// Sorts a nearly sorted stream with a min-heap of window_k+1 entries kept in
// a synchronous RAM; emits the minimum per item once full, flushes on final.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------
//  input    | in_valid, in_ready, in_item      | valid/ready
//  output   | out_valid, out_ready, out_item   | valid/ready, registered
//  config   | cfg_we, cfg_wdata (window_k)     | write strobe, no wait
//
//  While filling, the new value rises level by level; once full, the top is
//  emitted and the replacement sinks level by level.
//  Each level is one RAM read and one compare-and-write.
//  A final item then flushes the remaining entries in order.
//  Reset clears the count, window and controller; heap contents need none.
//  A stalled output holds the controller only when a new result is due.
//
module k_sorted_stream_sorter
	import kss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [WIN_W-1:0] cfg_wdata
);

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [WIN_W-1:0]    window_q;
	logic                fin_q;
	logic                flush_q;
	logic [ADDR_W-1:0]   i_q;
	logic [DATA_W-1:0]   x_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_ra;
	logic [ADDR_W-1:0]   ram_rb;
	logic [DATA_W-1:0]   rd_a;
	logic [DATA_W-1:0]   rd_b;

	logic                push;
	logic                push_ok;
	out_item_t           push_item;

	logic                in_acc;
	logic [CNT_W-1:0]    cap;
	logic                at_full;
	logic [ADDR_W+1:0]   l_idx;
	logic [ADDR_W+1:0]   r_idx;
	logic [ADDR_W+1:0]   n_ext;
	logic                dn_leaf;
	logic                pick_r;
	logic [DATA_W-1:0]   m_val;
	logic [ADDR_W-1:0]   m_idx;
	logic                dn_move;
	logic                up_move;
	logic [ADDR_W-1:0]   i_dec;
	logic [ADDR_W-1:0]   p_idx;
	logic [ADDR_W-1:0]   last_idx;

	// heap storage
	kss_ram #(
		.DEPTH (HEAP_DEPTH),
		.WIDTH (DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_ra),
		.raddr_b (ram_rb),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// result register
	kss_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.push_ok   (push_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// capacity and fullness
	assign cap     = CNT_W'({1'b0, window_q}) + CNT_W'(1);
	assign at_full = (count_q >= cap);

	// child and parent indices
	assign l_idx    = {1'b0, i_q, 1'b1};
	assign r_idx    = l_idx + (ADDR_W+2)'(1);
	assign n_ext    = (ADDR_W+2)'(count_q);
	assign dn_leaf  = (l_idx >= n_ext);
	assign i_dec    = i_q - ADDR_W'(1);
	assign p_idx    = {1'b0, i_dec[ADDR_W-1:1]};
	assign last_idx = ADDR_W'(count_q - CNT_W'(1));

	// smaller child and move decisions
	assign pick_r  = (r_idx < n_ext) && ($signed(rd_b) < $signed(rd_a));
	assign m_val   = pick_r ? rd_b : rd_a;
	assign m_idx   = pick_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
	assign dn_move = $signed(m_val) < $signed(x_q);
	assign up_move = $signed(x_q) < $signed(rd_a);

	// result item from the heap top
	assign push               = (state_q == S_EMIT) && push_ok;
	assign push_item.sorted_value = rd_a;
	assign push_item.is_last  = flush_q && (count_q == CNT_W'(1));

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = x_q;
		ram_re    = 1'b0;
		ram_ra    = '0;
		ram_rb    = '0;
		case (state_q)
			S_RD_TOP: begin
				ram_re = 1'b1;
				ram_rb = last_idx;
			end
			S_DN_RD: begin
				if (dn_leaf) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
					ram_ra = l_idx[ADDR_W-1:0];
					ram_rb = r_idx[ADDR_W-1:0];
				end
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (dn_move) begin
					ram_wdata = m_val;
				end
			end
			S_UP_RD: begin
				if (i_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
					ram_ra = p_idx;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (up_move) begin
					ram_wdata = rd_a;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			fin_q   <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						fin_q <= in_item.is_final;
						if (at_full) begin
							state_q <= S_RD_TOP;
						end else begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_UP_RD;
						end
					end
				end
				S_RD_TOP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (push_ok) begin
						if (flush_q) begin
							count_q <= count_q - CNT_W'(1);
							if (count_q == CNT_W'(1)) begin
								flush_q <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_DN_RD;
							end
						end else begin
							state_q <= S_DN_RD;
						end
					end
				end
				S_DN_RD: begin
					if (dn_leaf) begin
						if (fin_q || flush_q) begin
							flush_q <= 1'b1;
							state_q <= S_RD_TOP;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (dn_move) begin
						state_q <= S_DN_RD;
					end else if (fin_q || flush_q) begin
						flush_q <= 1'b1;
						state_q <= S_RD_TOP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_UP_RD: begin
					if (i_q == '0) begin
						if (fin_q) begin
							flush_q <= 1'b1;
							state_q <= S_RD_TOP;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_move) begin
						state_q <= S_UP_RD;
					end else if (fin_q) begin
						flush_q <= 1'b1;
						state_q <= S_RD_TOP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sift position and the value being placed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					x_q <= in_item.value;
					i_q <= count_q[ADDR_W-1:0];
				end
			end
			S_EMIT: begin
				if (push_ok) begin
					i_q <= '0;
					if (flush_q) begin
						x_q <= rd_b;
					end
				end
			end
			S_DN_CMP: begin
				if (dn_move) begin
					i_q <= m_idx;
				end
			end
			S_UP_CMP: begin
				if (up_move) begin
					i_q <= p_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// count never exceeds the heap depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_DEPTH))
		else $error("heap count above depth");

	// a result is only loaded into a free output slot
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid || out_ready))
		else $error("result pushed into a full output register");

	// back in idle, no flush is pending
	a_idle_no_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !flush_q)
		else $error("flush still pending in idle");

	// a final item leaves its flag for the flush
	a_final_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_item.is_final) |=> fin_q)
		else $error("final flag lost");

	// flush pop with a heap still holding entries never goes idle early
	a_flush_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(push && flush_q && (count_q != CNT_W'(1))) |=> (state_q == S_DN_RD))
		else $error("flush left before heap emptied");

endmodule
